FILE: src/vsp_pkg.sv
// Package: shared types and constants for the vertex screen projection block.
package vsp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_W_HI,
		ST_W_LO,
		ST_W_SUM,
		ST_LIN,
		ST_N_MUL,
		ST_N_DIV,
		ST_N_WAIT,
		ST_V_LO,
		ST_V_HI,
		ST_V_SUM,
		ST_DONE
	} vsp_state_t;

	typedef enum logic [2:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_CENTER_Z  = 3'd2,
		REG_FIT_SCALE = 3'd3,
		REG_VP_WIDTH  = 3'd4,
		REG_VP_HEIGHT = 3'd5
	} vsp_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} vsp_div_stat_t;

	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 27;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 36;
	localparam int DIV_Q_W = 62;

	localparam logic [25:0] K_X = 26'd58359637;
	localparam logic [25:0] K_Y = 26'd17596093;
	localparam logic [25:0] K_Z = 26'd55643730;

	function automatic logic [25:0] ndc_gain(input logic [1:0] idx);
		logic [25:0] k;
		case (idx)
			2'd0: k = K_X;
			2'd1: k = K_Y;
			default: k = K_Z;
		endcase
		return k;
	endfunction

endpackage

FILE: src/vsp_mul.sv
// Shared signed multiplier with a registered product.
module vsp_mul
	import vsp_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

FILE: src/vsp_div.sv
// Iterative restoring divider, one quotient bit a cycle, signed truncating result.
module vsp_div
	import vsp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [DIV_N_W-1:0] num,
	input  logic signed [DIV_D_W-1:0] den,
	output logic signed [DIV_N_W-1:0] quot,
	output vsp_div_stat_t             stat
);

	logic [DIV_Q_W-1:0] qn_q;
	logic [DIV_D_W-1:0] dmag_q;
	logic [DIV_D_W-1:0] rem_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [DIV_N_W-1:0] num_mag;
	logic [DIV_D_W-1:0] den_mag;
	logic [DIV_D_W:0]   trial;
	logic               fits;

	always_comb begin
		num_mag = num[DIV_N_W-1] ? DIV_N_W'(-num) : DIV_N_W'(num);
		den_mag = den[DIV_D_W-1] ? DIV_D_W'(-den) : DIV_D_W'(den);
		trial   = {rem_q, qn_q[DIV_Q_W-1]};
		fits    = trial >= {1'b0, dmag_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qn_q   <= num_mag[DIV_Q_W-1:0];
			dmag_q <= den_mag;
			rem_q  <= '0;
			neg_q  <= num[DIV_N_W-1] ^ den[DIV_D_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? DIV_D_W'(trial - {1'b0, dmag_q}) : trial[DIV_D_W-1:0];
			qn_q  <= {qn_q[DIV_Q_W-2:0], fits};
		end
	end

	always_comb begin
		quot = neg_q ? -$signed({2'b00, qn_q}) : $signed({2'b00, qn_q});
		stat.busy = busy_q;
		stat.done = done_q;
	end

endmodule

FILE: src/vertex_screen_projection.sv
// Top level: vertex transform, perspective divide and viewport under a sequencer.
//
//  channel | dir | handshake              | payload
//  s       | in  | s_tvalid / s_tready    | s_tdata: obj_x, obj_y, obj_z; s_tuser: first_of_mesh
//  m       | out | m_tvalid / m_tready    | m_tdata: screen_x, screen_y, depth, min, max
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One vertex runs the world multiplies, a linear step, then per axis the multiply/issue steps,
// a wait on the divider and the viewport steps, then an output step and an idle step. The
// 62-bit restoring divider, run three times, takes most of a vertex's time. A new vertex is
// only accepted in the idle step, so one vertex leaves the sequencer before the next enters.
// arst_n clears the sequencer, output valid, registers to their reset values and
// the depth extremes. A stalled result waits in the output register while the
// next vertex is accepted; the sequencer holds in its last step if it is still full.
module vertex_screen_projection
	import vsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // obj_x[31:0], obj_y[63:32], obj_z[95:64]
	input  logic [0:0]  s_tuser,   // first_of_mesh[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // screen_x, screen_y, screen_depth, min, max, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic signed [63:0] W_MAX   = 64'sd2147483647;
	localparam logic signed [63:0] W_MIN   = -64'sd2147483648;
	localparam logic signed [63:0] NDC_MAX = 64'sd2199023255552;
	localparam logic signed [63:0] NDC_MIN = -64'sd2199023255552;

	vsp_state_t state_q, state_d;

	logic signed [31:0] center_q [3];
	logic [31:0]        fit_scale_q;
	logic [13:0]        vp_w_q, vp_h_q;

	logic signed [31:0] obj_q [3];
	logic               first_q;
	logic [1:0]         idx_q;
	logic signed [31:0] world_q [3];
	logic signed [35:0] num_q [3];
	logic signed [35:0] den_q;
	logic signed [63:0] acc_q;
	logic signed [42:0] ndc_q;
	logic signed [15:0] res_q [3];
	logic signed [10:0] dmin_q, dmax_q;
	logic               m_tvalid_q;
	logic [71:0]        m_tdata_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic                      div_start;
	logic signed [DIV_N_W-1:0] div_q;
	vsp_div_stat_t             div_stat;

	logic signed [32:0] diff;
	logic signed [63:0] prod;
	logic signed [63:0] low_t;
	logic signed [63:0] wsum;
	logic signed [31:0] world_new;
	logic signed [35:0] wx, wy, wz;
	logic signed [35:0] lin_a, lin_b, lin_s;
	logic signed [42:0] ndc_new;
	logic signed [42:0] tpos;
	logic [13:0]        vp_size;
	logic signed [63:0] vsum;
	logic signed [63:0] vtr;
	logic signed [15:0] scr_new;
	logic               out_free;
	logic signed [10:0] dz;
	logic signed [10:0] nmin, nmax;

	vsp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	vsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (64'(mul_p)),
		.den    (den_q),
		.quot   (div_q),
		.stat   (div_stat)
	);

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_W_HI;
			ST_W_HI:   state_d = ST_W_LO;
			ST_W_LO:   state_d = ST_W_SUM;
			ST_W_SUM:  state_d = (idx_q == 2'd2) ? ST_LIN : ST_W_HI;
			ST_LIN:    state_d = ST_N_MUL;
			ST_N_MUL:  state_d = ST_N_DIV;
			ST_N_DIV:  state_d = ST_N_WAIT;
			ST_N_WAIT: if (div_stat.done) state_d = ST_V_LO;
			ST_V_LO:   state_d = ST_V_HI;
			ST_V_HI:   state_d = ST_V_SUM;
			ST_V_SUM:  state_d = (idx_q == 2'd2) ? ST_DONE : ST_N_MUL;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath selection
	always_comb begin
		diff    = 33'(obj_q[idx_q]) - 33'(center_q[idx_q]);
		prod    = 64'(mul_p);
		low_t   = (prod >>> 16) + ((prod < 0 && prod[15:0] != 16'd0) ? 64'sd1 : 64'sd0);
		wsum    = acc_q + low_t;
		world_new = (wsum > W_MAX) ? 32'sh7fffffff :
			(wsum < W_MIN) ? 32'sh80000000 : 32'(wsum);

		wx    = 36'(world_q[0]);
		wy    = 36'(world_q[1]);
		wz    = 36'(world_q[2]);
		lin_a = (wx <<< 1) + wx - wz;
		lin_b = (wy <<< 3) + (wy <<< 1) - wx - (wz <<< 1) - wz;
		lin_s = wx + wy + (wz <<< 1) + wz;

		if (den_q == 36'sd0)
			ndc_new = (num_q[idx_q] > 0) ? 43'(NDC_MAX) :
				(num_q[idx_q] < 0) ? 43'(NDC_MIN) : 43'sd0;
		else
			ndc_new = (div_q > NDC_MAX) ? 43'(NDC_MAX) :
				(div_q < NDC_MIN) ? 43'(NDC_MIN) : 43'(div_q);

		tpos = ndc_q + 43'sd16777216;
		case (idx_q)
			2'd0:    vp_size = vp_w_q;
			2'd1:    vp_size = vp_h_q;
			default: vp_size = 14'd255;
		endcase
		vsum = (prod <<< 25) + acc_q;
		vtr  = (vsum >>> 25) + ((vsum < 0 && vsum[24:0] != 25'd0) ? 64'sd1 : 64'sd0);
		if (idx_q == 2'd2)
			scr_new = (vtr > 64'sd1023) ? 16'sd1023 :
				(vtr < -64'sd1024) ? -16'sd1024 : 16'(vtr);
		else
			scr_new = (vtr > 64'sd32767) ? 16'sh7fff :
				(vtr < -64'sd32768) ? 16'sh8000 : 16'(vtr);

		dz   = 11'(res_q[2]);
		nmin = (first_q || dz < dmin_q) ? dz : dmin_q;
		nmax = (first_q || dz > dmax_q) ? dz : dmax_q;
	end

	// sequencer outputs: multiplier operands and divider start
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			ST_W_HI: begin
				mul_a = MUL_A_W'(diff);
				mul_b = $signed({11'd0, fit_scale_q[31:16]});
			end
			ST_W_LO: begin
				mul_a = MUL_A_W'(diff);
				mul_b = $signed({11'd0, fit_scale_q[15:0]});
			end
			ST_N_MUL: begin
				mul_a = num_q[idx_q];
				mul_b = $signed({1'b0, ndc_gain(idx_q)});
			end
			ST_N_DIV: div_start = 1'b1;
			ST_V_LO: begin
				mul_a = $signed({11'd0, tpos[24:0]});
				mul_b = $signed({13'd0, vp_size});
			end
			ST_V_HI: begin
				mul_a = MUL_A_W'($signed(tpos[42:25]));
				mul_b = $signed({13'd0, vp_size});
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			m_tvalid_q  <= 1'b0;
			dmin_q      <= 11'sd1023;
			dmax_q      <= -11'sd1024;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			fit_scale_q <= 32'd65536;
			vp_w_q      <= 14'd800;
			vp_h_q      <= 14'd800;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_CENTER_X:  center_q[0] <= cfg_data;
					REG_CENTER_Y:  center_q[1] <= cfg_data;
					REG_CENTER_Z:  center_q[2] <= cfg_data;
					REG_FIT_SCALE: fit_scale_q <= cfg_data;
					REG_VP_WIDTH:  vp_w_q      <= cfg_data[13:0];
					REG_VP_HEIGHT: vp_h_q      <= cfg_data[13:0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  idx_q <= '0;
				ST_W_SUM: idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				ST_V_SUM: idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				ST_DONE: begin
					if (out_free) begin
						dmin_q     <= nmin;
						dmax_q     <= nmax;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				obj_q[0] <= s_tdata[31:0];
				obj_q[1] <= s_tdata[63:32];
				obj_q[2] <= s_tdata[95:64];
				first_q  <= s_tuser[0];
			end
			ST_W_LO:   acc_q <= prod;
			ST_W_SUM:  world_q[idx_q] <= world_new;
			ST_LIN: begin
				num_q[0] <= lin_a;
				num_q[1] <= lin_b;
				num_q[2] <= lin_s;
				den_q    <= 36'sd720896 - lin_s;
			end
			ST_N_WAIT: ndc_q <= ndc_new;
			ST_V_HI:   acc_q <= prod;
			ST_V_SUM:  res_q[idx_q] <= scr_new;
			ST_DONE: begin
				if (out_free)
					m_tdata_q <= {7'd0, nmax, nmin, dz, res_q[1], res_q[0]};
			end
			default: ;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again without a full pass");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[53:43]) <= $signed(m_tdata[64:54]))
		else $error("running depth min exceeds max");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_N_WAIT)
		else $error("divider finished outside its wait step");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

endmodule

FILE: test/tb_top.sv
// Testbench for vertex_screen_projection: directed and random vertices checked by a fixed-point predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import vsp_pkg::*;

	localparam longint NDC_CAP = 64'sd1 << 41;
	localparam longint Q24_ONE = 64'sd1 << 24;
	localparam longint Q25_ONE = 64'sd1 << 25;
	localparam longint GAIN_X = 58359637;
	localparam longint GAIN_Y = 17596093;
	localparam longint GAIN_Z = 55643730;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [10:0] depth;
		logic signed [10:0] dmin;
		logic signed [10:0] dmax;
	} pixel_t;

	class projection_scoreboard;
		logic [31:0] ctr_x, ctr_y, ctr_z, scale;
		logic [13:0] vp_w, vp_h;
		logic signed [10:0] run_min, run_max;
		pixel_t pending_pixels[$];
		int errors;

		function void init();
			ctr_x = 0; ctr_y = 0; ctr_z = 0; scale = 32'd65536;
			vp_w = 14'd800; vp_h = 14'd800;
			run_min = 11'sd1023; run_max = -11'sd1024;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_CENTER_X: ctr_x = data;
				REG_CENTER_Y: ctr_y = data;
				REG_CENTER_Z: ctr_z = data;
				REG_FIT_SCALE: scale = data;
				REG_VP_WIDTH: vp_w = data[13:0];
				REG_VP_HEIGHT: vp_h = data[13:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint to_world(logic [31:0] obj, logic [31:0] ctr);
			longint d, hi_part, lo_part;
			d = longint'($signed(obj)) - longint'($signed(ctr));
			hi_part = longint'(scale[31:16]);
			lo_part = longint'(scale[15:0]);
			return clip(d * hi_part + (d * lo_part) / 65536, -64'sd2147483648, 64'sd2147483647);
		endfunction

		function longint ndc_div(longint num, longint den);
			if (den == 0)
				return num > 0 ? NDC_CAP : (num < 0 ? -NDC_CAP : 0);
			return clip(num / den, -NDC_CAP, NDC_CAP);
		endfunction

		function longint to_pixel(longint ndc, longint size, longint lo, longint hi);
			return clip(size * (Q24_ONE + ndc) / Q25_ONE, lo, hi);
		endfunction

		function void note_vertex(logic [95:0] data, logic first);
			longint x, y, z, a, b, s, den, dz;
			pixel_t p;
			x = to_world(data[31:0], ctr_x);
			y = to_world(data[63:32], ctr_y);
			z = to_world(data[95:64], ctr_z);
			a = 3 * x - z;
			b = -x + 10 * y - 3 * z;
			s = x + y + 3 * z;
			den = 11 * 65536 - s;
			p.sx = to_pixel(ndc_div(a * GAIN_X, den), longint'(vp_w), -32768, 32767);
			p.sy = to_pixel(ndc_div(b * GAIN_Y, den), longint'(vp_h), -32768, 32767);
			dz = to_pixel(ndc_div(s * GAIN_Z, den), 255, -1024, 1023);
			p.depth = dz;
			if (first) begin
				run_min = dz;
				run_max = dz;
			end else begin
				if (dz < run_min) run_min = dz;
				if (dz > run_max) run_max = dz;
			end
			p.dmin = run_min;
			p.dmax = run_max;
			pending_pixels = {pending_pixels, p};
		endfunction

		function void check_pixel(logic [71:0] data);
			pixel_t e;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected word %h", $time, data);
				errors++;
				return;
			end
			e = pending_pixels.pop_front();
			if (data[15:0] !== e.sx) begin
				$display("%0t: screen_x exp %0d got %0d", $time, e.sx, $signed(data[15:0]));
				errors++;
			end
			if (data[31:16] !== e.sy) begin
				$display("%0t: screen_y exp %0d got %0d", $time, e.sy, $signed(data[31:16]));
				errors++;
			end
			if (data[42:32] !== e.depth) begin
				$display("%0t: depth exp %0d got %0d", $time, e.depth, $signed(data[42:32]));
				errors++;
			end
			if (data[53:43] !== e.dmin) begin
				$display("%0t: depth_min exp %0d got %0d", $time, e.dmin, $signed(data[53:43]));
				errors++;
			end
			if (data[64:54] !== e.dmax) begin
				$display("%0t: depth_max exp %0d got %0d", $time, e.dmax, $signed(data[64:54]));
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	projection_scoreboard sb;
	bit burst_mode;

	vertex_screen_projection u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int draw_gap();
		return burst_mode ? 0 : $urandom_range(0, 18);
	endfunction

	task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic first);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {vz, vy, vx};
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		sb.note_vertex({vz, vy, vx}, first);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] near_coord(logic [31:0] ctr);
		return ctr + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
	endfunction

	task automatic random_vertices(int count);
		logic [31:0] vx, vy, vz;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				vx = $urandom; vy = $urandom; vz = $urandom;
			end else begin
				vx = near_coord(sb.ctr_x);
				vy = near_coord(sb.ctr_y);
				vz = near_coord(sb.ctr_z);
			end
			send_vertex(vx, vy, vz, $urandom_range(0, 9) == 0);
		end
	endtask

	always begin
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			m_tready <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		m_tready <= 1'b1;
		do @(posedge clk); while (m_tvalid !== 1'b1);
		sb.check_pixel(m_tdata);
	end

	initial begin
		#10ms;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		sb = new();
		sb.init();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, eye plane, eye point, behind eye
		send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
		send_vertex(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b1);
		send_vertex(32'h0002_0000, 32'h0, 32'h0003_0000, 1'b0);
		send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 1'b0);
		send_vertex(32'h0003_0000, 32'h0, 32'h0003_0000, 1'b0);
		send_vertex(32'h0, 32'h0, 32'h000A_0000, 1'b1);
		send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0);
		send_vertex(32'h0, 32'h0, 32'hFFF6_0000, 1'b0);
		random_vertices(90);

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					write_reg(REG_CENTER_X, 32'h8000_0000);
					write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
					write_reg(REG_CENTER_Z, 32'h0);
					write_reg(REG_FIT_SCALE, 32'hFFFF_FFFF);
					write_reg(REG_VP_WIDTH, 32'd8192);
					write_reg(REG_VP_HEIGHT, 32'd1);
				end
				1: begin
					write_reg(REG_FIT_SCALE, 32'h0);
					write_reg(REG_VP_WIDTH, 32'd0);
					write_reg(REG_VP_HEIGHT, 32'h3FFF);
					write_reg(3'd6, $urandom);
					write_reg(3'd7, $urandom);
				end
				2: begin
					write_reg(REG_CENTER_X, 32'h0);
					write_reg(REG_CENTER_Y, 32'h0);
					write_reg(REG_CENTER_Z, 32'h8000_0000);
					write_reg(REG_FIT_SCALE, 32'h0000_E666);
					write_reg(REG_VP_WIDTH, 32'hFFFF_FFFF);
					write_reg(REG_VP_HEIGHT, 32'd8192);
				end
				3: begin
					write_reg(REG_CENTER_Z, 32'h7FFF_FFFF);
					write_reg(REG_FIT_SCALE, 32'h0000_0001);
				end
				default: begin
					write_reg(REG_CENTER_X, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000F_FFFF));
					write_reg(REG_CENTER_Y, $urandom);
					write_reg(REG_CENTER_Z, $urandom_range(0, 32'h000F_FFFF));
					write_reg(REG_FIT_SCALE, $urandom_range(0, 32'h0004_0000));
					write_reg(REG_VP_WIDTH, $urandom_range(1, 8192));
					write_reg(REG_VP_HEIGHT, $urandom);
				end
			endcase
			@(posedge clk);
			send_vertex(sb.ctr_x, sb.ctr_y, sb.ctr_z, 1'b1);
			random_vertices(89);
		end

		s_tvalid <= 1'b0;
		fork
			while (sb.pending_pixels.size() != 0) @(posedge clk);
			begin
				repeat (20000) @(posedge clk);
				sb.errors++;
			end
		join_any
		disable fork;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule

FILE: sim.f
src/vsp_pkg.sv
src/vsp_mul.sv
src/vsp_div.sv
src/vertex_screen_projection.sv
test/tb_top.sv
